// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the LED matrix scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lmps_pkg.sv =====
// Shared constants and types of the LED matrix PWM scanner.
package lmps_pkg;

  localparam int ROW_COUNT    = 5;
  localparam int COLUMN_COUNT = 5;

  // Fixed widths of the item fields.
  localparam int DRIVE_W = 5;
  localparam int INDEX_W = 3;
  localparam int BYTE_W  = 8;

  // Rows that can show on the 5-bit row port.
  localparam int LIT_ROWS = (ROW_COUNT < DRIVE_W) ? ROW_COUNT : DRIVE_W;

  localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_STEPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_TICKS = 2'd2;

  // One column of brightness bytes, one lane per row.
  typedef logic [ROW_COUNT-1:0][BYTE_W-1:0] col_bytes_t;
  typedef logic [ROW_COUNT-1:0]             row_mask_t;

  // What the sequencer shows for one tick.
  typedef struct packed {
    logic              on;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] step;
  } scan_view_t;

endpackage

// ===== hw/rtl/lmps_table.sv =====
// Brightness memory: one word per column with a byte lane per row, plus write pointer.
`include "assert_macros.svh"

module lmps_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [lmps_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [lmps_pkg::COL_W-1:0] rd_col,
  output lmps_pkg::col_bytes_t      rd_data,
  output lmps_pkg::row_mask_t       rd_vld
);

  lmps_pkg::col_bytes_t mem [lmps_pkg::COLUMN_COUNT];
  logic [lmps_pkg::COLUMN_COUNT-1:0][lmps_pkg::ROW_COUNT-1:0] vld;

  // Write pointer split into row and column, row-major order.
  logic [lmps_pkg::ROW_W-1:0] wr_row;
  logic [lmps_pkg::COL_W-1:0] wr_col;
  logic                       col_last;
  logic                       row_last;

  assign col_last = (wr_col == lmps_pkg::COL_W'(lmps_pkg::COLUMN_COUNT - 1));
  assign row_last = (wr_row == lmps_pkg::ROW_W'(lmps_pkg::ROW_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_row <= '0;
      wr_col <= '0;
    end else if (wr_en) begin
      if (col_last) begin
        wr_col <= '0;
        wr_row <= row_last ? '0 : wr_row + lmps_pkg::ROW_W'(1);
      end else begin
        wr_col <= wr_col + lmps_pkg::COL_W'(1);
      end
    end
  end

  // Per-entry valid bits stand in for the cleared table after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_col][wr_row] <= 1'b1;
    end
  end

  // Byte-lane write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col][wr_row] <= wr_data;
    end
  end

  // Registered column read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_col];
      rd_vld  <= vld[rd_col];
    end
  end

  `ASSERT_ON(a_wr_sets_valid, wr_en |=> vld[$past(wr_col)][$past(wr_row)], "written entry not valid")

endmodule

// ===== hw/rtl/lmps_scan.sv =====
// Scan sequencer: configuration registers, PWM/hold/blank phases and column stepping.
`include "assert_macros.svh"

module lmps_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lmps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            tick,
  output lmps_pkg::scan_view_t            view
);

  typedef enum logic [2:0] {
    PH_PWM   = 3'b001,
    PH_HOLD  = 3'b010,
    PH_BLANK = 3'b100
  } phase_t;

  logic [lmps_pkg::BYTE_W-1:0] pwm_steps;
  logic [15:0]                 hold_ticks;
  logic [15:0]                 blank_ticks;

  phase_t                      phase, phase_next;
  logic [lmps_pkg::COL_W-1:0]  col, col_next;
  logic [lmps_pkg::BYTE_W-1:0] pwm_step, pwm_step_next;
  logic [15:0]                 phase_ticks, phase_ticks_next;

  logic [lmps_pkg::BYTE_W-1:0] steps_eff;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_steps   <= 8'd12;
      hold_ticks  <= 16'd1;
      blank_ticks <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        lmps_pkg::REG_PWM_STEPS:   pwm_steps   <= cfg_data[lmps_pkg::BYTE_W-1:0];
        lmps_pkg::REG_HOLD_TICKS:  hold_ticks  <= cfg_data;
        lmps_pkg::REG_BLANK_TICKS: blank_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero steps behaves as one.
  assign steps_eff = (pwm_steps == '0) ? lmps_pkg::BYTE_W'(1) : pwm_steps;

  // Phase transitions that fire on entry to a tick, then the tick itself.
  always_comb begin
    phase_t                      ph;
    logic [lmps_pkg::COL_W-1:0]  c;
    logic [lmps_pkg::BYTE_W-1:0] ps;
    logic [15:0]                 pt;

    case (phase)
      PH_PWM, PH_HOLD, PH_BLANK: ph = phase;
      default:                   ph = PH_PWM;
    endcase
    c  = (int'(col) >= lmps_pkg::COLUMN_COUNT) ? '0 : col;
    ps = pwm_step;
    pt = phase_ticks;

    if (ph == PH_PWM && ps >= steps_eff) begin
      ph = PH_HOLD;
      pt = '0;
    end
    if (ph == PH_HOLD && pt >= hold_ticks) begin
      ph = PH_BLANK;
      pt = '0;
    end
    if (ph == PH_BLANK && pt >= blank_ticks) begin
      c  = (c == lmps_pkg::COL_W'(lmps_pkg::COLUMN_COUNT - 1)) ? '0
                                                               : c + lmps_pkg::COL_W'(1);
      ph = PH_PWM;
      ps = '0;
      pt = '0;
    end

    view.col = c;
    case (ph)
      PH_PWM: begin
        view.on   = 1'b1;
        view.step = ps;
        ps        = ps + lmps_pkg::BYTE_W'(1);
      end
      PH_HOLD: begin
        // Hold shows the last displayed step.
        view.on   = 1'b1;
        view.step = ps - lmps_pkg::BYTE_W'(1);
        pt        = pt + 16'd1;
      end
      default: begin
        view.on   = 1'b0;
        view.step = '0;
        pt        = pt + 16'd1;
      end
    endcase

    phase_next       = ph;
    col_next         = c;
    pwm_step_next    = ps;
    phase_ticks_next = pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PWM;
      col         <= '0;
      pwm_step    <= '0;
      phase_ticks <= '0;
    end else if (tick) begin
      phase       <= phase_next;
      col         <= col_next;
      pwm_step    <= pwm_step_next;
      phase_ticks <= phase_ticks_next;
    end
  end

  `ASSERT_ON(a_new_column, tick && (col_next != col) |-> (phase_next == PH_PWM) && (pwm_step_next == lmps_pkg::BYTE_W'(1)), "column change must start PWM at step 0")

endmodule

// ===== hw/rtl/led_matrix_pwm_scanner.sv =====
// Top level of the LED matrix PWM scanner: handshakes, output stage and row compare.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | kind, data_byte
//  out      | out_valid / out_stall| column_drive, row_drive, column_index
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// One item per cycle, unless a tick is held by a waiting result. A tick reads its
// column from the brightness memory in the cycle it is taken; its result is in the
// output register in the cycle after. Byte items write one memory lane and give no
// result. On reset, valid bits clear the table and the scan restarts at column 0.
// A waiting result stalls ticks only; bytes keep flowing into the table.
`include "assert_macros.svh"

module led_matrix_pwm_scanner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [lmps_pkg::BYTE_W-1:0]      data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lmps_pkg::DRIVE_W-1:0]     column_drive,
  output logic [lmps_pkg::DRIVE_W-1:0]     row_drive,
  output logic [lmps_pkg::INDEX_W-1:0]     column_index,
  input  logic                             cfg_write,
  input  logic [lmps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                 tick_acc;
  logic                 byte_acc;
  lmps_pkg::scan_view_t view;
  lmps_pkg::scan_view_t out_q;
  lmps_pkg::col_bytes_t rd_data;
  lmps_pkg::row_mask_t  rd_vld;
  logic                 out_valid_next;

  // Only a tick needs the output register.
  assign in_stall = out_valid && out_stall && kind;
  assign tick_acc = in_valid && !in_stall && kind;
  assign byte_acc = in_valid && !in_stall && !kind;

  lmps_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_acc),
    .view      (view)
  );

  lmps_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (byte_acc),
    .wr_data (data_byte),
    .rd_en   (tick_acc),
    .rd_col  (view.col),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  // Output stage.
  assign out_valid_next = tick_acc || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_q <= view;
    end
  end

  // Column one-hot, rows lit where the step is below the brightness.
  always_comb begin
    column_drive = '0;
    row_drive    = '1;
    for (int i = 0; i < lmps_pkg::DRIVE_W; i++) begin
      if (i < lmps_pkg::COLUMN_COUNT && out_q.on && out_q.col == lmps_pkg::COL_W'(i)) begin
        column_drive[i] = 1'b1;
      end
    end
    for (int r = 0; r < lmps_pkg::LIT_ROWS; r++) begin
      if (out_q.on && rd_vld[r] && out_q.step < rd_data[r]) begin
        row_drive[r] = 1'b0;
      end
    end
  end

  assign column_index = lmps_pkg::INDEX_W'(out_q.col);

  `ASSERT_ON(a_blank_dark, out_valid && !out_q.on |-> (row_drive == '1) && (column_drive == '0), "blanking must drive nothing")
  `ASSERT_ON(a_byte_keeps_result, byte_acc && out_valid |=> $stable(row_drive) && $stable(column_drive), "byte write disturbed a pending result")

endmodule
